// ===== hdl/acsp_pkg.sv =====
// Package for the ANSI CSI sequence parser: word types, character codes,
// action codes and the final-byte decoder. No dependencies.
package acsp_pkg;

   // Number of parameter fields carried in a result word
   localparam int OUT_PARAMS = 8;

   // Character codes
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;   // '['
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;   // ';'
   localparam logic [7:0] CH_ZERO      = 8'h30;   // '0'
   localparam logic [7:0] CH_NINE      = 8'h39;   // '9'
   localparam logic [7:0] CH_FINAL_M   = 8'h6D;   // 'm'
   localparam logic [7:0] CH_FINAL_A   = 8'h41;   // 'A'
   localparam logic [7:0] CH_FINAL_B   = 8'h42;   // 'B'
   localparam logic [7:0] CH_FINAL_C   = 8'h43;   // 'C'
   localparam logic [7:0] CH_FINAL_D   = 8'h44;   // 'D'
   localparam logic [7:0] CH_FINAL_H   = 8'h48;   // 'H'
   localparam logic [7:0] CH_FINAL_J   = 8'h4A;   // 'J'
   localparam logic [7:0] CH_FINAL_K   = 8'h4B;   // 'K'
   localparam logic [7:0] CH_FINAL_S   = 8'h53;   // 'S'
   localparam logic [7:0] CH_FINAL_T   = 8'h54;   // 'T'

   // Parameter of 'J' that selects a full screen clear
   localparam int CLEAR_ALL_ARG = 2;

   // Action codes
   localparam logic [3:0] ACT_NONE         = 4'd0;
   localparam logic [3:0] ACT_PLAIN        = 4'd1;
   localparam logic [3:0] ACT_COLOR        = 4'd2;
   localparam logic [3:0] ACT_UP           = 4'd3;
   localparam logic [3:0] ACT_DOWN         = 4'd4;
   localparam logic [3:0] ACT_RIGHT        = 4'd5;
   localparam logic [3:0] ACT_LEFT         = 4'd6;
   localparam logic [3:0] ACT_POSITION     = 4'd7;
   localparam logic [3:0] ACT_CLEAR_SCREEN = 4'd8;
   localparam logic [3:0] ACT_CLEAR_LINE   = 4'd9;
   localparam logic [3:0] ACT_SCROLL_UP    = 4'd10;
   localparam logic [3:0] ACT_SCROLL_DOWN  = 4'd11;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_ESC  = 3'b010,
      PH_CSI  = 3'b100
   } phase_type;

   // Input word
   typedef struct packed {
      logic [7:0] in_byte;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  char_out;
      logic [3:0]  arg_count;
      logic [15:0] param_0;
      logic [15:0] param_1;
      logic [15:0] param_2;
      logic [15:0] param_3;
      logic [15:0] param_4;
      logic [15:0] param_5;
      logic [15:0] param_6;
      logic [15:0] param_7;
   } rsp_word_type;

   // Map a final byte to its action; 'J' only clears when the first arg is 2
   function automatic logic [3:0] decode_final(input logic [7:0] final_byte,
                                               input logic       first_is_two);
      logic [3:0] act;
      case (final_byte)
         CH_FINAL_M: act = ACT_COLOR;
         CH_FINAL_A: act = ACT_UP;
         CH_FINAL_B: act = ACT_DOWN;
         CH_FINAL_C: act = ACT_RIGHT;
         CH_FINAL_D: act = ACT_LEFT;
         CH_FINAL_H: act = ACT_POSITION;
         CH_FINAL_J: act = first_is_two ? ACT_CLEAR_SCREEN : ACT_NONE;
         CH_FINAL_K: act = ACT_CLEAR_LINE;
         CH_FINAL_S: act = ACT_SCROLL_UP;
         CH_FINAL_T: act = ACT_SCROLL_DOWN;
         default:    act = ACT_NONE;
      endcase
      return act;
   endfunction

endpackage

// ===== hdl/acsp_stream_if.sv =====
// Valid/ready stream channel used for both the byte input and the result
// output of the parser. Payload type is set per instance.
interface acsp_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== hdl/acsp_parse_core.sv =====
// Parser state (phase, field index, field values) and the per-byte decode
// that forms one result word. Depends on acsp_pkg.
module acsp_parse_core #(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output acsp_pkg::rsp_word_type result
);
   import acsp_pkg::*;

   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int PRD_W = PARAM_BITS + 4;
   localparam int CLP_W = PARAM_BITS + 16;

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PARAM_BITS-1:0] values_ff [MAX_PARAMS];
   logic [PARAM_BITS-1:0] values_in [MAX_PARAMS];

   logic                  is_digit;
   logic                  slot_open;
   logic [3:0]            digit;
   logic [IDX_W-1:0]      idx;
   logic [PARAM_BITS-1:0] cur_value;
   logic [PRD_W-1:0]      prod;
   logic [PARAM_BITS-1:0] sat_value;
   logic [5:0]            cnt_sat;
   logic [3:0]            final_act;
   logic [15:0]           param_out [OUT_PARAMS];
   logic [CLP_W-1:0]      clamp_wide [OUT_PARAMS];

   // Digit accumulate: value*10 + digit, saturating at the field maximum
   always_comb begin
      is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
      digit     = 4'(in_byte - CH_ZERO);
      slot_open = (CNT_W + 1)'(count_ff) < (CNT_W + 1)'(MAX_PARAMS);
      idx       = count_ff[IDX_W-1:0];
      cur_value = values_ff[idx];
      prod      = ({4'b0, cur_value} << 3) + ({4'b0, cur_value} << 1)
                  + {{PARAM_BITS{1'b0}}, digit};
      sat_value = (|prod[PRD_W-1:PARAM_BITS]) ? {PARAM_BITS{1'b1}}
                                               : prod[PARAM_BITS-1:0];
   end

   // Parameter count of a finished sequence, saturated at the slot count and 15
   always_comb begin
      cnt_sat = 6'(count_ff) + 6'd1;
      if (cnt_sat > 6'(MAX_PARAMS)) begin
         cnt_sat = 6'(MAX_PARAMS);
      end
      if (cnt_sat > 6'd15) begin
         cnt_sat = 6'd15;
      end
      final_act = decode_final(in_byte,
                               values_ff[0] == PARAM_BITS'(CLEAR_ALL_ARG));
   end

   // Output fields: clamp to 16 bits, slots past MAX_PARAMS read zero
   always_comb begin
      for (int j = 0; j < OUT_PARAMS; j++) begin
         clamp_wide[j] = '0;
         param_out[j]  = '0;
         if (j < MAX_PARAMS) begin
            clamp_wide[j] = CLP_W'(values_ff[j]);
            param_out[j]  = (|clamp_wide[j][CLP_W-1:16]) ? 16'hFFFF
                                                          : clamp_wide[j][15:0];
         end
      end
   end

   // Phase transitions and result word
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      values_in = values_ff;
      result    = '0;
      result.char_out = in_byte;
      case (phase_ff)
         PH_ESC: begin
            count_in  = '0;
            values_in = '{default: '0};
            if (in_byte == CH_LBRACKET) begin
               phase_in = PH_CSI;
            end else begin
               phase_in      = PH_IDLE;
               result.action = ACT_PLAIN;
            end
         end
         PH_CSI: begin
            if (is_digit) begin
               if (slot_open) begin
                  values_in[idx] = sat_value;
               end
            end else if (in_byte == CH_SEMICOLON) begin
               if (slot_open) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               if (final_act != ACT_NONE) begin
                  result.action    = final_act;
                  result.arg_count = cnt_sat[3:0];
                  result.param_0   = param_out[0];
                  result.param_1   = param_out[1];
                  result.param_2   = param_out[2];
                  result.param_3   = param_out[3];
                  result.param_4   = param_out[4];
                  result.param_5   = param_out[5];
                  result.param_6   = param_out[6];
                  result.param_7   = param_out[7];
               end
               count_in  = '0;
               values_in = '{default: '0};
               phase_in  = PH_IDLE;
            end
         end
         default: begin
            if (in_byte == CH_ESC) begin
               phase_in = PH_ESC;
            end else begin
               phase_in      = PH_IDLE;
               result.action = ACT_PLAIN;
            end
         end
      endcase
   end

   // State registers advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         values_ff <= '{default: '0};
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         values_ff <= values_in;
      end
   end

endmodule

// ===== hdl/acsp_out_reg.sv =====
// Result register: holds one result word until the sink takes it, and
// frees itself in the same cycle it is drained. Depends on acsp_pkg.
module acsp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  acsp_pkg::rsp_word_type result,
   output logic                  can_load,
   acsp_stream_if.source         rsp_stream
);
   import acsp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   // Space when empty or when the held word leaves this cycle
   assign can_load = !valid_ff || rsp_stream.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_stream.valid   = valid_ff;
   assign rsp_stream.payload = word_ff;

endmodule

// ===== hdl/ansi_csi_sequence_parser_top.sv =====
// Top level of the ANSI CSI sequence parser: parse core plus result register.
// Depends on acsp_pkg, acsp_stream_if, acsp_parse_core, acsp_out_reg.
//
//   channel      dir   payload                        handshake
//   req_stream   in    acsp_pkg::req_word_type         valid/ready
//   rsp_stream   out   acsp_pkg::rsp_word_type         valid/ready
//
// One result word per input byte; rsp_stream.valid rises in the cycle after the accept.
// A byte can be taken every cycle unless the sink stalls; the parser state updates at
// the accept edge and the result register is the only stage between input and output.
// Synchronous reset returns the parser to idle with all parameters cleared.
// req_stream.ready drops only while a held result waits on a stalled sink.
module ansi_csi_sequence_parser_top #(
   parameter int MAX_PARAMS = 8,
   parameter int PARAM_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   acsp_stream_if.sink   req_stream,
   acsp_stream_if.source rsp_stream
);
   import acsp_pkg::*;

   logic         can_load;
   logic         accept;
   rsp_word_type result;

   assign req_stream.ready = can_load;
   assign accept           = req_stream.valid && can_load;

   acsp_parse_core #(
      .MAX_PARAMS (MAX_PARAMS),
      .PARAM_BITS (PARAM_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_stream.payload.in_byte),
      .result  (result)
   );

   acsp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_stream (rsp_stream)
   );

endmodule

// ===== dv/tb_ansi_csi_sequence_parser_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ansi_csi_sequence_parser_top: directed and random byte
// streams with a local predictor of the parser. Depends on acsp_pkg and acsp_stream_if.
module tb_ansi_csi_sequence_parser_top;
   import acsp_pkg::*;

   localparam int RANDOM_BYTES = 1250;
   localparam int LONG_HOLD    = 300;   // sink hold-off that backs up the input
   localparam int HOLD_AT      = 400;   // result count at which that hold starts
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [7:0]   code;
      bit           typed;    // want is given in the row, not by the predictor
      rsp_word_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   acsp_stream_if #(.payload_type(req_word_type)) req_stream ();
   acsp_stream_if #(.payload_type(rsp_word_type)) rsp_stream ();

   ansi_csi_sequence_parser_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream)
   );

   // Predicted parser state
   phase_type   parse_state;
   int          arg_index;
   logic [15:0] arg_vals [OUT_PARAMS];

   rsp_word_type expected_words [$];
   stim_row_type stim_rows [25];
   logic [7:0]   final_codes [10] = '{CH_FINAL_M, CH_FINAL_A, CH_FINAL_B, CH_FINAL_C,
                                      CH_FINAL_D, CH_FINAL_H, CH_FINAL_J, CH_FINAL_K,
                                      CH_FINAL_S, CH_FINAL_T};

   int fail_count;
   int sent_count;
   int got_count;
   int send_mode;
   int plain_seen;
   int dropped_seen;
   int decoded_seen;
   int max_count_seen;
   int input_stall_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Time limit
   initial begin
      #5_000_000;
      $display("tb_ansi_csi_sequence_parser_top NOT OK");
      $finish;
   end

   function automatic logic [7:0] digit_char(input int n);
      return 8'(CH_ZERO + n);
   endfunction

   function automatic rsp_word_type word_of(input logic [3:0] act, input logic [7:0] ch,
                                            input logic [3:0] cnt, input logic [15:0] p0);
      rsp_word_type w;
      w = '0;
      w.action    = act;
      w.char_out  = ch;
      w.arg_count = cnt;
      w.param_0   = p0;
      return w;
   endfunction

   function automatic void clear_args();
      arg_index = 0;
      foreach (arg_vals[i]) arg_vals[i] = '0;
   endfunction

   function automatic logic [3:0] action_for_final(input logic [7:0] b);
      case (b)
         CH_FINAL_M: return ACT_COLOR;
         CH_FINAL_A: return ACT_UP;
         CH_FINAL_B: return ACT_DOWN;
         CH_FINAL_C: return ACT_RIGHT;
         CH_FINAL_D: return ACT_LEFT;
         CH_FINAL_H: return ACT_POSITION;
         CH_FINAL_J: return (arg_vals[0] == CLEAR_ALL_ARG) ? ACT_CLEAR_SCREEN : ACT_NONE;
         CH_FINAL_K: return ACT_CLEAR_LINE;
         CH_FINAL_S: return ACT_SCROLL_UP;
         CH_FINAL_T: return ACT_SCROLL_DOWN;
         default:    return ACT_NONE;
      endcase
   endfunction

   // Advance the predicted state by one byte and return the word it should produce
   function automatic rsp_word_type parse_byte(input logic [7:0] b);
      rsp_word_type w;
      int           acc;
      int           cnt;
      logic [3:0]   act;
      w = '0;
      w.char_out = b;
      case (parse_state)
         PH_ESC: begin
            clear_args();
            if (b == CH_LBRACKET) begin
               parse_state = PH_CSI;
            end else begin
               parse_state = PH_IDLE;
               w.action    = ACT_PLAIN;
            end
         end
         PH_CSI: begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
               // digits past the last slot are ignored; values saturate
               if (arg_index < OUT_PARAMS) begin
                  acc = int'(arg_vals[arg_index]) * 10 + int'(b - CH_ZERO);
                  arg_vals[arg_index] = (acc > 65535) ? 16'hFFFF : 16'(acc);
               end
            end else if (b == CH_SEMICOLON) begin
               if (arg_index < OUT_PARAMS) arg_index++;
            end else begin
               act = action_for_final(b);
               cnt = (arg_index + 1 > OUT_PARAMS) ? OUT_PARAMS : arg_index + 1;
               if (act != ACT_NONE) begin
                  w.action    = act;
                  w.arg_count = 4'(cnt);
                  w.param_0   = arg_vals[0];
                  w.param_1   = arg_vals[1];
                  w.param_2   = arg_vals[2];
                  w.param_3   = arg_vals[3];
                  w.param_4   = arg_vals[4];
                  w.param_5   = arg_vals[5];
                  w.param_6   = arg_vals[6];
                  w.param_7   = arg_vals[7];
               end
               clear_args();
               parse_state = PH_IDLE;
            end
         end
         default: begin
            parse_state = PH_IDLE;
            if (b == CH_ESC) parse_state = PH_ESC;
            else w.action = ACT_PLAIN;
         end
      endcase
      return w;
   endfunction

   // Gap before a word: none, occasional, or always random
   function automatic int draw_gap(input int mode);
      case (mode)
         0:       return 0;
         1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         default: return $urandom_range(0, 19);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Offer one byte, wait for the accept, then record what it should produce
   task automatic send_byte(input logic [7:0] code, input bit typed,
                            input rsp_word_type typed_word);
      int           gap;
      rsp_word_type predicted;
      if (sent_count % 64 == 0) send_mode = $urandom_range(0, 2);
      gap = draw_gap(send_mode);
      repeat (gap) begin
         @(negedge clock);
         req_stream.valid <= 1'b0;
      end
      @(negedge clock);
      req_stream.valid           <= 1'b1;
      req_stream.payload.in_byte <= code;
      do @(posedge clock); while (!req_stream.ready);
      predicted = parse_byte(code);
      expected_words.push_back(typed ? typed_word : predicted);
      sent_count++;
   endtask

   // Compare one result word with the oldest pending one
   task automatic take_result(input rsp_word_type got);
      rsp_word_type want;
      got_count++;
      if (got.action == ACT_PLAIN) plain_seen++;
      else if (got.action == ACT_NONE) dropped_seen++;
      else decoded_seen++;
      if (int'(got.arg_count) > max_count_seen) max_count_seen = int'(got.arg_count);
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t: expected no result word, got %h", $time, got);
         return;
      end
      want = expected_words.pop_front();
      check_field("action", 16'(want.action), 16'(got.action));
      check_field("char_out", 16'(want.char_out), 16'(got.char_out));
      check_field("arg_count", 16'(want.arg_count), 16'(got.arg_count));
      check_field("param_0", want.param_0, got.param_0);
      check_field("param_1", want.param_1, got.param_1);
      check_field("param_2", want.param_2, got.param_2);
      check_field("param_3", want.param_3, got.param_3);
      check_field("param_4", want.param_4, got.param_4);
      check_field("param_5", want.param_5, got.param_5);
      check_field("param_6", want.param_6, got.param_6);
      check_field("param_7", want.param_7, got.param_7);
   endtask

   // Result sink with random stalls and one long hold-off
   initial begin
      int gap;
      int mode;
      bit held;
      mode = 0;
      held = 1'b0;
      rsp_stream.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (got_count % 64 == 0) mode = $urandom_range(0, 2);
         gap = draw_gap(mode);
         if (!held && got_count == HOLD_AT) begin
            gap  = LONG_HOLD;
            held = 1'b1;
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_stream.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_stream.ready <= 1'b1;
         do @(posedge clock); while (!rsp_stream.valid);
         take_result(rsp_stream.payload);
      end
   end

   // Count cycles where the block holds off an offered byte
   always @(posedge clock) begin
      if (!reset && req_stream.valid && !req_stream.ready) input_stall_cycles++;
   end

   // Stimulus and end of run
   initial begin
      logic [7:0] seq [$];
      logic [7:0] final_code;
      int         kind;
      int         n_args;
      int         n_digits;
      int         random_count;
      req_stream.valid   = 1'b0;
      req_stream.payload = '0;
      reset              = 1'b1;
      parse_state        = PH_IDLE;
      clear_args();
      random_count       = 0;

      // Directed rows: plain extremes, lone ESC, saturation, clear screen, ESC inside CSI
      stim_rows = '{
         '{8'h41,         1'b1, word_of(ACT_PLAIN, 8'h41, 4'd0, 16'd0)},
         '{8'h00,         1'b1, word_of(ACT_PLAIN, 8'h00, 4'd0, 16'd0)},
         '{8'hFF,         1'b1, word_of(ACT_PLAIN, 8'hFF, 4'd0, 16'd0)},
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)},
         '{8'h78,         1'b1, word_of(ACT_PLAIN, 8'h78, 4'd0, 16'd0)},   // ESC then not '['
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)},
         '{CH_LBRACKET,   1'b1, word_of(ACT_NONE, CH_LBRACKET, 4'd0, 16'd0)},
         '{digit_char(7), 1'b0, '0},                                 // 70000 saturates
         '{digit_char(0), 1'b0, '0},
         '{digit_char(0), 1'b0, '0},
         '{digit_char(0), 1'b0, '0},
         '{digit_char(0), 1'b0, '0},
         '{CH_SEMICOLON,  1'b0, '0},
         '{digit_char(5), 1'b0, '0},
         '{CH_FINAL_M,    1'b0, '0},
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)},
         '{CH_LBRACKET,   1'b1, word_of(ACT_NONE, CH_LBRACKET, 4'd0, 16'd0)},
         '{digit_char(2), 1'b1, word_of(ACT_NONE, digit_char(2), 4'd0, 16'd0)},
         '{CH_FINAL_J,    1'b1, word_of(ACT_CLEAR_SCREEN, CH_FINAL_J, 4'd1, 16'd2)},
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)},
         '{CH_LBRACKET,   1'b1, word_of(ACT_NONE, CH_LBRACKET, 4'd0, 16'd0)},
         '{CH_FINAL_J,    1'b1, word_of(ACT_NONE, CH_FINAL_J, 4'd0, 16'd0)},  // 'J' without 2
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)},
         '{CH_LBRACKET,   1'b1, word_of(ACT_NONE, CH_LBRACKET, 4'd0, 16'd0)},
         '{CH_ESC,        1'b1, word_of(ACT_NONE, CH_ESC, 4'd0, 16'd0)}       // ESC ends the CSI
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) send_byte(stim_rows[r].code, stim_rows[r].typed,
                                       stim_rows[r].want);

      // Random part: mostly well-formed sequences, some plain text and broken ones
      while (random_count < RANDOM_BYTES) begin
         seq.delete();
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            final_code = final_codes[$urandom_range(0, 9)];
            if ($urandom_range(0, 7) == 0) begin
               do final_code = 8'($urandom_range(0, 255));
               while ((final_code >= CH_ZERO && final_code <= CH_NINE) ||
                      final_code == CH_SEMICOLON);
            end
            seq.push_back(CH_ESC);
            seq.push_back(CH_LBRACKET);
            if (final_code == CH_FINAL_J && $urandom_range(0, 1) == 1) begin
               seq.push_back(digit_char(CLEAR_ALL_ARG));
            end else begin
               // now and then more parameters than there are slots
               n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11)
                                                    : $urandom_range(0, 3);
               for (int a = 0; a < n_args; a++) begin
                  if (a > 0) seq.push_back(CH_SEMICOLON);
                  n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(0, 3);
                  repeat (n_digits) seq.push_back(digit_char($urandom_range(0, 9)));
               end
            end
            seq.push_back(final_code);
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
         end else begin
            seq.push_back(CH_ESC);
            if ($urandom_range(0, 1) == 1) seq.push_back(CH_LBRACKET);
            repeat ($urandom_range(1, 5)) seq.push_back(8'($urandom_range(0, 255)));
         end
         foreach (seq[j]) send_byte(seq[j], 1'b0, '0);
         random_count += seq.size();
      end

      @(negedge clock);
      req_stream.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; results: %0d plain, %0d dropped, %0d decoded sequences",
               sent_count, plain_seen, dropped_seen, decoded_seen);
      $display("Largest parameter count %0d; input held off for %0d cycles; %0d mismatches",
               max_count_seen, input_stall_cycles, fail_count);
      if (fail_count == 0)
         $display("tb_ansi_csi_sequence_parser_top OK");
      else
         $display("tb_ansi_csi_sequence_parser_top NOT OK");
      $finish;
   end

endmodule
